// ----- hdl/ufg_pkg.sv -----
`default_nettype none
package ufg_pkg;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_MAC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_MAC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_IP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_IP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_PORT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_PORT = 3'd5;
  localparam int CFG_DATA_W = 48;

  // Stream payload widths.
  localparam int PLEN_W   = 9;
  localparam int S_DATA_W = 16;
  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 4;
  localparam int M_DATA_W = 72;

  // Fixed header fields.
  localparam int          HDR_BYTES     = 42;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TOS        = 8'h00;
  localparam logic [15:0] IP_ID         = 16'h0000;
  localparam logic [15:0] IP_FLAGS_DF   = 16'h4000;
  localparam logic [7:0]  IP_TTL        = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [15:0] UDP_CSUM      = 16'h0000;
  localparam logic [15:0] IP_HDR_LEN    = 16'd20;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;

  // Sum of the constant header words, used to seed the checksum.
  localparam int SUM_W = 19;
  localparam logic [SUM_W-1:0] IP_SUM_BASE =
    SUM_W'({IP_VER_IHL, IP_TOS}) + SUM_W'(IP_ID) + SUM_W'(IP_FLAGS_DF) +
    SUM_W'({IP_TTL, IP_PROTO_UDP});

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CSUM,
    ST_SEND
  } ufg_state_t;

  typedef struct packed {
    logic load;
    logic fold;
    logic emit;
  } ufg_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } ufg_status_t;

endpackage
`default_nettype wire

// ----- hdl/ufg_ctrl.sv -----
`default_nettype none
module ufg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire ufg_pkg::ufg_status_t status,
  output ufg_pkg::ufg_cmd_t        cmd
);
  import ufg_pkg::*;

  ufg_state_t state;
  ufg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CSUM;
      end
      ST_CSUM: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (status.out_free && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_CSUM: begin
        cmd.fold = 1'b1;
      end
      ST_SEND: begin
        cmd.emit = status.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/ufg_datapath.sv -----
`default_nettype none
module ufg_datapath #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ufg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ufg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [ufg_pkg::PLEN_W-1:0]        payload_len,
  input  wire ufg_pkg::ufg_cmd_t                 cmd,
  output ufg_pkg::ufg_status_t                   status,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [ufg_pkg::WORD_W-1:0]             word_data,
  output logic [ufg_pkg::COUNT_W-1:0]            byte_count,
  output logic                                   last_word
);
  import ufg_pkg::*;

  localparam int LEN_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int WIDX_W = $clog2((MAX_FRAME_BYTES + 7) / 8);
  localparam logic [PLEN_W-1:0] MaxPay = PLEN_W'(MAX_FRAME_BYTES - HDR_BYTES);

  logic [47:0] dest_mac;
  logic [47:0] src_mac;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] src_port;
  logic [15:0] dst_port;

  logic [PLEN_W-1:0] plen;
  logic [LEN_W-1:0]  total;
  logic [SUM_W-1:0]  sum_raw;
  logic [15:0]       csum;
  logic [WIDX_W-1:0] widx;

  logic [PLEN_W-1:0] plen_clamp;
  logic [15:0]       ip_len;
  logic [15:0]       udp_len;
  logic [16:0]       fold1;
  logic [15:0]       fold2;
  logic [47:0][7:0]  hdr;
  logic [63:0]       hdr_word;
  logic [15:0]       total16;
  logic [15:0]       base16;
  logic [15:0]       rem16;
  logic [63:0]       word_next;
  logic [3:0]        count_next;
  logic              last_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_mac <= '0;
      src_mac  <= '0;
      src_ip   <= '0;
      dst_ip   <= '0;
      src_port <= '0;
      dst_port <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_MAC: dest_mac <= cfg_data;
        REG_SRC_MAC:  src_mac  <= cfg_data;
        REG_SRC_IP:   src_ip   <= cfg_data[31:0];
        REG_DST_IP:   dst_ip   <= cfg_data[31:0];
        REG_SRC_PORT: src_port <= cfg_data[15:0];
        REG_DST_PORT: dst_port <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign plen_clamp = (payload_len > MaxPay) ? MaxPay : payload_len;
  assign ip_len     = IP_HDR_LEN + UDP_HDR_LEN + 16'(plen);
  assign udp_len    = UDP_HDR_LEN + 16'(plen);

  // Checksum: the raw sum is taken at load, folded twice in the next cycle.
  assign fold1 = {1'b0, sum_raw[15:0]} + 17'(sum_raw[SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      plen    <= plen_clamp;
      total   <= LEN_W'(plen_clamp) + LEN_W'(HDR_BYTES);
      sum_raw <= IP_SUM_BASE
               + SUM_W'(IP_HDR_LEN + UDP_HDR_LEN + 16'(plen_clamp))
               + SUM_W'(src_ip[31:16]) + SUM_W'(src_ip[15:0])
               + SUM_W'(dst_ip[31:16]) + SUM_W'(dst_ip[15:0]);
    end
    if (cmd.fold) begin
      csum <= ~fold2;
    end
  end

  always_comb begin
    hdr = '0;
    for (int i = 0; i < 6; i++) begin
      hdr[i]     = dest_mac[47-8*i -: 8];
      hdr[6 + i] = src_mac[47-8*i -: 8];
    end
    hdr[12] = ETH_TYPE_IPV4[15:8];
    hdr[13] = ETH_TYPE_IPV4[7:0];
    hdr[14] = IP_VER_IHL;
    hdr[15] = IP_TOS;
    hdr[16] = ip_len[15:8];
    hdr[17] = ip_len[7:0];
    hdr[18] = IP_ID[15:8];
    hdr[19] = IP_ID[7:0];
    hdr[20] = IP_FLAGS_DF[15:8];
    hdr[21] = IP_FLAGS_DF[7:0];
    hdr[22] = IP_TTL;
    hdr[23] = IP_PROTO_UDP;
    hdr[24] = csum[15:8];
    hdr[25] = csum[7:0];
    for (int i = 0; i < 4; i++) begin
      hdr[26 + i] = src_ip[31-8*i -: 8];
      hdr[30 + i] = dst_ip[31-8*i -: 8];
    end
    hdr[34] = src_port[15:8];
    hdr[35] = src_port[7:0];
    hdr[36] = dst_port[15:8];
    hdr[37] = dst_port[7:0];
    hdr[38] = udp_len[15:8];
    hdr[39] = udp_len[7:0];
    hdr[40] = UDP_CSUM[15:8];
    hdr[41] = UDP_CSUM[7:0];
  end

  // Header word picked by the word index; words past the header read zero.
  always_comb begin
    hdr_word = '0;
    if (16'(widx) < 16'd6) begin
      unique case (widx[2:0])
        3'd0:    hdr_word = hdr[7:0];
        3'd1:    hdr_word = hdr[15:8];
        3'd2:    hdr_word = hdr[23:16];
        3'd3:    hdr_word = hdr[31:24];
        3'd4:    hdr_word = hdr[39:32];
        3'd5:    hdr_word = hdr[47:40];
        default: hdr_word = '0;
      endcase
    end
  end

  assign total16 = 16'(total);
  assign base16  = 16'(widx) << 3;
  assign rem16   = total16 - base16;

  always_comb begin
    logic [15:0] pos;
    logic [15:0] pay;
    word_next = '0;
    for (int k = 0; k < 8; k++) begin
      pos = base16 + 16'(k);
      pay = pos - 16'(HDR_BYTES);
      if (pos < total16) begin
        if (pos < 16'(HDR_BYTES)) word_next[8*k +: 8] = hdr_word[8*k +: 8];
        else                      word_next[8*k +: 8] = pay[7:0];
      end
    end
  end

  assign count_next = (rem16 > 16'd8) ? 4'd8 : rem16[3:0];
  assign last_next  = (base16 + 16'd8) >= total16;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      widx <= '0;
    end else if (cmd.emit) begin
      widx <= widx + 1'b1;
    end
    if (cmd.emit) begin
      word_data  <= word_next;
      byte_count <= count_next;
      last_word  <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign status.out_free = !m_tvalid || m_tready;
  assign status.last     = last_next;

endmodule
`default_nettype wire

// ----- hdl/udp_frame_generator_top.sv -----
`default_nettype none
// Channel  | Direction | Handshake          | Contents
// ---------+-----------+--------------------+-------------------------------------------
// s_*      | in        | s_tvalid/s_tready  | tdata[8:0] payload_len, rest zero
// m_*      | out       | m_tvalid/m_tready  | tdata[63:0] word_data, [67:64] byte_count;
//          |           |                    | tlast last_word
// cfg_*    | in        | cfg_we             | cfg_index selects register, cfg_data value
//
// A request is taken in an idle cycle, then the IPv4 header checksum is folded; then the
// frame goes out as ceil((42 + payload_len) / 8) 8-byte beats, one beat per cycle while
// the output side does not stall (18 beats for a 100-byte payload).
// A new request is taken as soon as the last beat sits in the output register.
// Reset (rst, synchronous) returns the controller to idle, drops m_tvalid and clears
// all addresses and ports to zero. A stall on m_tready holds the counter and the beat.
module udp_frame_generator_top #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // s_tdata fields from bit 0: payload_len[8:0], zero fill.
  input  wire logic [ufg_pkg::S_DATA_W-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // m_tdata fields from bit 0: word_data[63:0], byte_count[67:64], zero fill.
  output logic [ufg_pkg::M_DATA_W-1:0]          m_tdata,
  output logic                                  m_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [ufg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ufg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ufg_pkg::*;

  ufg_cmd_t            cmd;
  ufg_status_t         status;
  logic [WORD_W-1:0]   word_data;
  logic [COUNT_W-1:0]  byte_count;

  ufg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ufg_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .payload_len (s_tdata[PLEN_W-1:0]),
    .cmd         (cmd),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .word_data   (word_data),
    .byte_count  (byte_count),
    .last_word   (m_tlast)
  );

  // Pack the beat: data word low, byte count above it, zero fill to a byte boundary.
  assign m_tdata = {{(M_DATA_W - WORD_W - COUNT_W){1'b0}}, byte_count, word_data};

endmodule
`default_nettype wire
